[hw/rtl/blst_pkg.sv]
// Shared types and constants for the bounded ordered list.
`default_nettype none

package blst_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_INSERT     = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Where an insert lands: front, just past the last entry, or at the scan result.
  typedef enum logic [1:0] {
    POS_FRONT = 2'd0,
    POS_BACK  = 2'd1,
    POS_SCAN  = 2'd2
  } pos_sel_t;

  typedef struct packed {
    logic     ins;
    logic     pop;
    logic     load;
    logic     step;
    pos_sel_t pos_sel;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/blst_in_if.sv]
// Input channel: operation words with valid/ready handshake.
`default_nettype none

interface blst_in_if;
  logic                                valid;
  logic                                ready;
  logic        [blst_pkg::OP_W-1:0]    op;
  logic signed [blst_pkg::DATA_W-1:0]  data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

`default_nettype wire

[hw/rtl/blst_out_if.sv]
// Result channel: one result word per operation with valid/ready handshake.
`default_nettype none

interface blst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [blst_pkg::DATA_W-1:0]  out_value;
  logic        [blst_pkg::STAT_W-1:0]  status;
  logic        [blst_pkg::ENTRY_W-1:0] entry_count;

  modport source (output valid, output out_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input out_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/bounded_ordered_list.sv]
// Top level: bounded ordered list of signed words built as a row of slot cells.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+----------------------------------------
//   in_ch    | in  | valid/ready      | op[1:0], data_in[31:0] signed
//   out_ch   | out | valid/ready      | out_value[31:0] signed, status[1:0],
//            |     |                  | entry_count[4:0]
//
// Push front, push back, pop, a dropped push, and an ordered insert that lands at
// the head or goes into a one-entry list finish when they are accepted. Any other ordered
// insert first runs a scan: the match and tail flags travel one slot per cycle
// along the row, and the final shift also waits while a result word is stalled.
// Reset (rst_n low, synchronous) empties the list; slot contents are not cleared.
// A stalled result sits in the output register; the next word is accepted once
// the register is free or being drained in the same cycle.
`default_nettype none

module bounded_ordered_list #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  blst_in_if.sink    in_ch,
  blst_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  blst_pkg::cell_ctl_t                ctl;
  logic signed [blst_pkg::DATA_W-1:0] cell_v;
  logic        [CW-1:0]               cell_count;

  logic signed [blst_pkg::DATA_W-1:0] e_w  [DEPTH];
  logic                               p_w  [DEPTH];
  logic                               ge_w [DEPTH];
  logic                               tw_w [DEPTH];

  blst_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_op      (in_ch.op),
    .in_data    (in_ch.data_in),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_value  (out_ch.out_value),
    .out_status (out_ch.status),
    .out_count  (out_ch.entry_count),
    .head       (e_w[0]),
    .head_tw    (tw_w[0]),
    .ctl        (ctl),
    .cell_v     (cell_v),
    .cell_count (cell_count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [blst_pkg::DATA_W-1:0] e_left;
    logic                               p_left;
    logic                               ge_left;
    logic signed [blst_pkg::DATA_W-1:0] e_right;
    logic                               tw_right;

    if (i == 0) begin : g_head
      assign e_left  = '0;
      assign p_left  = 1'b0;
      assign ge_left = 1'b0;
    end else begin : g_mid
      assign e_left  = e_w[i-1];
      assign p_left  = p_w[i-1];
      assign ge_left = ge_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign e_right  = '0;
      assign tw_right = 1'b0;
    end else begin : g_body
      assign e_right  = e_w[i+1];
      assign tw_right = tw_w[i+1];
    end

    blst_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .v        (cell_v),
      .count    (cell_count),
      .e_left   (e_left),
      .p_left   (p_left),
      .ge_left  (ge_left),
      .e_right  (e_right),
      .tw_right (tw_right),
      .e        (e_w[i]),
      .p        (p_w[i]),
      .ge       (ge_w[i]),
      .tw       (tw_w[i])
    );
  end

endmodule

`default_nettype wire

[hw/rtl/blst_cell.sv]
// One list slot: holds an entry and the scan flags, trades data with both neighbors.
`default_nettype none

module blst_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  blst_pkg::cell_ctl_t                ctl,
  input  logic signed [blst_pkg::DATA_W-1:0] v,
  input  logic        [CW-1:0]               count,
  input  logic signed [blst_pkg::DATA_W-1:0] e_left,
  input  logic                               p_left,
  input  logic                               ge_left,
  input  logic signed [blst_pkg::DATA_W-1:0] e_right,
  input  logic                               tw_right,
  output logic signed [blst_pkg::DATA_W-1:0] e,
  output logic                               p,
  output logic                               ge,
  output logic                               tw
);

  logic signed [blst_pkg::DATA_W-1:0] e_r, e_nxt;
  logic                               ge_r, ge_nxt;
  logic                               tw_r, tw_nxt;
  logic                               past_end;
  logic                               match;
  logic                               tail_hit;

  assign past_end = (CW'(IDX) >= count);
  // Head slot never takes part in the scan.
  assign match    = (IDX != 0) && (e_r >= v);
  assign tail_hit = (CW'(IDX + 1) == count) && (v >= e_r);

  // p: the insert position is at or before this slot.
  always_comb begin
    case (ctl.pos_sel)
      blst_pkg::POS_FRONT: p = 1'b1;
      blst_pkg::POS_BACK:  p = past_end;
      blst_pkg::POS_SCAN:  p = ge_r | past_end;
      default:             p = 1'b0;
    endcase
  end

  always_comb begin
    e_nxt = e_r;
    if (ctl.ins && p) begin
      e_nxt = p_left ? e_left : v;
    end else if (ctl.pop) begin
      e_nxt = e_right;
    end
  end

  // ge ripples toward the tail (first match from the front),
  // tw ripples toward the head (tail compare result).
  always_comb begin
    ge_nxt = ge_r;
    tw_nxt = tw_r;
    if (ctl.load) begin
      ge_nxt = match;
      tw_nxt = tail_hit;
    end else if (ctl.step) begin
      ge_nxt = ge_r | ge_left;
      tw_nxt = tw_r | tw_right;
    end
  end

  always_ff @(posedge clk) begin
    e_r  <= e_nxt;
    ge_r <= ge_nxt;
    tw_r <= tw_nxt;
  end

  assign e  = e_r;
  assign ge = ge_r;
  assign tw = tw_r;

endmodule

`default_nettype wire

[hw/rtl/blst_ctrl.sv]
// Sequencer: decodes operations, runs the scan wave, keeps the count and the result register.
`default_nettype none

module blst_ctrl #(
  parameter int DEPTH = 16,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic        [blst_pkg::OP_W-1:0]    in_op,
  input  logic signed [blst_pkg::DATA_W-1:0]  in_data,
  output logic                                in_ready,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [blst_pkg::DATA_W-1:0]  out_value,
  output logic        [blst_pkg::STAT_W-1:0]  out_status,
  output logic        [blst_pkg::ENTRY_W-1:0] out_count,
  input  logic signed [blst_pkg::DATA_W-1:0]  head,
  input  logic                                head_tw,
  output blst_pkg::cell_ctl_t                 ctl,
  output logic signed [blst_pkg::DATA_W-1:0]  cell_v,
  output logic        [CW-1:0]                cell_count
);

  blst_pkg::state_t                   state_r, state_nxt;
  logic        [CW-1:0]               count_r, count_nxt;
  logic        [CW-1:0]               steps_r, steps_nxt;
  logic signed [blst_pkg::DATA_W-1:0] v_r, v_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [blst_pkg::DATA_W-1:0] out_value_r;
  blst_pkg::status_t                  out_status_r;
  logic        [blst_pkg::ENTRY_W-1:0] out_count_r;

  logic                               out_free;
  logic                               accept;
  logic                               full;
  logic                               out_load;
  logic signed [blst_pkg::DATA_W-1:0] res_value;
  blst_pkg::status_t                  res_status;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    steps_nxt   = steps_r;
    v_nxt       = v_r;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    res_value   = '0;
    res_status  = blst_pkg::STAT_DONE;
    ctl.ins     = 1'b0;
    ctl.pop     = 1'b0;
    ctl.load    = 1'b0;
    ctl.step    = 1'b0;
    ctl.pos_sel = blst_pkg::POS_FRONT;
    cell_v      = v_r;

    unique case (state_r)
      blst_pkg::S_IDLE: begin
        in_ready = out_free;
        cell_v   = in_data;
        if (accept) begin
          v_nxt = in_data;
          if (blst_pkg::op_t'(in_op) == blst_pkg::OP_POP_FRONT) begin
            out_load = 1'b1;
            if (count_r == '0) begin
              res_status = blst_pkg::STAT_EMPTY;
            end else begin
              res_value = head;
              ctl.pop   = 1'b1;
              count_nxt = count_r - CW'(1);
            end
          end else if (full) begin
            out_load   = 1'b1;
            res_status = blst_pkg::STAT_FULL;
          end else begin
            res_status = (count_r == '0) ? blst_pkg::STAT_EMPTY : blst_pkg::STAT_DONE;
            case (blst_pkg::op_t'(in_op))
              blst_pkg::OP_PUSH_FRONT: begin
                ctl.ins     = 1'b1;
                ctl.pos_sel = blst_pkg::POS_FRONT;
              end
              blst_pkg::OP_PUSH_BACK: begin
                ctl.ins     = 1'b1;
                ctl.pos_sel = blst_pkg::POS_BACK;
              end
              default: begin
                if (count_r == '0 || in_data <= head) begin
                  ctl.ins     = 1'b1;
                  ctl.pos_sel = blst_pkg::POS_FRONT;
                end else if (count_r == CW'(1)) begin
                  ctl.ins     = 1'b1;
                  ctl.pos_sel = blst_pkg::POS_BACK;
                end else begin
                  // latch compares in every slot, then let the flags travel
                  ctl.load  = 1'b1;
                  steps_nxt = count_r - CW'(1);
                  state_nxt = blst_pkg::S_SCAN;
                end
              end
            endcase
            if (ctl.ins) begin
              out_load  = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
        end
      end

      blst_pkg::S_SCAN: begin
        if (steps_r != '0) begin
          ctl.step  = 1'b1;
          steps_nxt = steps_r - CW'(1);
        end else if (out_free) begin
          ctl.ins     = 1'b1;
          ctl.pos_sel = head_tw ? blst_pkg::POS_BACK : blst_pkg::POS_SCAN;
          out_load    = 1'b1;
          count_nxt   = count_r + CW'(1);
          state_nxt   = blst_pkg::S_IDLE;
        end
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blst_pkg::S_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (out_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= blst_pkg::ENTRY_W'(count_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign cell_count = count_r;

endmodule

`default_nettype wire

[hw/rtl/blst_chk.sv]
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module blst_chk #(
  parameter int DEPTH = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [blst_pkg::DATA_W-1:0]  out_value,
  input logic        [blst_pkg::STAT_W-1:0]  status,
  input logic        [blst_pkg::ENTRY_W-1:0] entry_count
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status)
                               && $stable(entry_count))
    else $error("result word changed while stalled");

  // dropped push leaves the list full and returns no value
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == blst_pkg::STAT_FULL |->
      entry_count == blst_pkg::ENTRY_W'(DEPTH) && out_value == '0)
    else $error("full status with wrong count or value");

  // empty before the op: pop gives zero and 0 entries, push leaves 1
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == blst_pkg::STAT_EMPTY |->
      out_value == '0 && (entry_count == 0 || entry_count == 1))
    else $error("empty status with wrong count or value");

  // no result word is shown in the cycle after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bounded_ordered_list blst_chk #(.DEPTH(DEPTH)) u_blst_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.out_value),
  .status      (out_ch.status),
  .entry_count (out_ch.entry_count)
);

`default_nettype wire

[sim/bounded_ordered_list_test.sv]
// Self-checking testbench for the bounded ordered list: directed and random operation words.
`timescale 1ns / 1ps

module bounded_ordered_list_test;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_OPS = 550;
  localparam int SETTLE     = 40;
  localparam int LIMIT      = 200000;

  localparam logic signed [blst_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [blst_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [blst_pkg::DATA_W-1:0] value;
    blst_pkg::status_t                  status;
    logic [blst_pkg::ENTRY_W-1:0]       count;
  } list_result_t;

  // Mirror of the list contents plus the FIFO of results still owed by the block.
  class list_scoreboard;
    logic signed [blst_pkg::DATA_W-1:0] slots[$];
    list_result_t                       owed[$];
    int unsigned                        errors;
    int unsigned                        checked;
    int unsigned                        drops;
    int unsigned                        empties;
    int unsigned                        scans;

    function int unsigned ordered_slot(logic signed [blst_pkg::DATA_W-1:0] v);
      if (slots.size() == 0 || v <= slots[0]) return 0;
      if (v >= slots[slots.size()-1]) return slots.size();
      scans++;
      for (int i = 1; i < slots.size(); i++) begin
        if (slots[i] >= v) return i;
      end
      return slots.size();
    endfunction

    function void note_op(blst_pkg::op_t op, logic signed [blst_pkg::DATA_W-1:0] v);
      list_result_t r;
      r.value  = '0;
      r.status = (slots.size() == 0) ? blst_pkg::STAT_EMPTY : blst_pkg::STAT_DONE;
      if (r.status == blst_pkg::STAT_EMPTY) empties++;
      if (op == blst_pkg::OP_POP_FRONT) begin
        if (slots.size() != 0) r.value = slots.pop_front();
      end else if (slots.size() >= LIST_DEPTH) begin
        r.status = blst_pkg::STAT_FULL;
        drops++;
      end else begin
        case (op)
          blst_pkg::OP_PUSH_FRONT: slots.push_front(v);
          blst_pkg::OP_PUSH_BACK:  slots.push_back(v);
          default:                 slots.insert(ordered_slot(v), v);
        endcase
      end
      r.count = blst_pkg::ENTRY_W'(slots.size());
      owed.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [blst_pkg::DATA_W-1:0] value,
                      logic [blst_pkg::STAT_W-1:0] status,
                      logic [blst_pkg::ENTRY_W-1:0] count);
      list_result_t want;
      if (owed.size() == 0) begin
        report_mismatch("result word with nothing pending");
        return;
      end
      want = owed.pop_front();
      checked++;
      if (value !== want.value)
        report_mismatch($sformatf("out_value %0d, want %0d", value, want.value));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (count !== want.count)
        report_mismatch($sformatf("entry_count %0d, want %0d", count, want.count));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned cycles;
  int unsigned sent;
  list_scoreboard sb;

  blst_in_if  in_ch ();
  blst_out_if out_ch ();

  bounded_ordered_list #(.DEPTH(LIST_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_value, out_ch.status, out_ch.entry_count);
  end

  task automatic send_word(input blst_pkg::op_t op,
                           input logic signed [blst_pkg::DATA_W-1:0] v);
    while (!calm && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.data_in <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_op(op, v);
    sent++;
  endtask

  // Mix of narrow values (for ties), corner values and full-range words.
  function automatic logic signed [blst_pkg::DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return blst_pkg::DATA_W'($signed($urandom_range(16)) - 8);
    if (roll < 50) begin
      case ($urandom_range(4))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return -1;
        3:       return 0;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic blst_pkg::op_t pick_op(int unsigned push_pct);
    int unsigned roll;
    if ($urandom_range(99) >= push_pct) return blst_pkg::OP_POP_FRONT;
    roll = $urandom_range(99);
    if (roll < 25) return blst_pkg::OP_PUSH_FRONT;
    if (roll < 50) return blst_pkg::OP_PUSH_BACK;
    return blst_pkg::OP_INSERT;
  endfunction

  initial begin
    int unsigned phase_len;
    int unsigned push_pct;
    sb            = new();
    cycles        = 0;
    sent          = 0;
    calm          = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = blst_pkg::OP_PUSH_FRONT;
    in_ch.data_in = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, head/tail ties, extremes, scan through unsorted contents, full list.
    send_word(blst_pkg::OP_POP_FRONT, 32'sd9);
    send_word(blst_pkg::OP_INSERT, 32'sd5);
    send_word(blst_pkg::OP_INSERT, VAL_MIN);
    send_word(blst_pkg::OP_INSERT, VAL_MAX);
    send_word(blst_pkg::OP_INSERT, 32'sd5);
    send_word(blst_pkg::OP_INSERT, 32'sd0);
    send_word(blst_pkg::OP_INSERT, VAL_MAX);
    send_word(blst_pkg::OP_INSERT, VAL_MIN);
    send_word(blst_pkg::OP_PUSH_FRONT, 32'sd100);
    send_word(blst_pkg::OP_INSERT, 32'sd50);
    send_word(blst_pkg::OP_PUSH_BACK, -32'sd3);
    send_word(blst_pkg::OP_PUSH_FRONT, -32'sd100);
    send_word(blst_pkg::OP_INSERT, 32'sd1);
    send_word(blst_pkg::OP_PUSH_BACK, 32'sd0);
    send_word(blst_pkg::OP_POP_FRONT, VAL_MAX);
    for (int i = 0; i < 4; i++) send_word(blst_pkg::OP_PUSH_BACK, 32'(-i));
    send_word(blst_pkg::OP_PUSH_FRONT, VAL_MAX);
    send_word(blst_pkg::OP_PUSH_BACK, VAL_MIN);
    send_word(blst_pkg::OP_INSERT, 32'sd2);
    send_word(blst_pkg::OP_POP_FRONT, -32'sd1);

    // Random phases each pick a push share at random, from mostly filling to mostly draining the list.
    while (sent < RANDOM_OPS) begin
      case ($urandom_range(3))
        0:       push_pct = 85;
        1:       push_pct = 20;
        2:       push_pct = 50;
        default: push_pct = 70;
      endcase
      phase_len = $urandom_range(40, 10);
      for (int i = 0; i < phase_len && sent < RANDOM_OPS; i++) begin
        calm = (sent >= 250 && sent < 350);
        send_word(pick_op(push_pct), pick_value());
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d operation words sent, %0d results checked", sent, sb.checked);
    $display("empty-list ops %0d, dropped pushes %0d, scanned inserts %0d, mismatches %0d",
             sb.empties, sb.drops, sb.scans, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
